### rtl/srpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srpc_pkg: shared definitions for the call rule priority classifier
// Table sizes, field widths, command and rule kind codes, and the structs
// that pass between the rule tables, the scan unit and the top level.
// ----------------------------------------------------------------------------
package srpc_pkg;

  localparam int RuleSlots = 64;
  localparam int ExcSlots  = 16;
  localparam int CallLimit = 512;

  localparam int CallW    = 9;
  localparam int IdxInW   = 6;
  localparam int SlotInW  = 4;
  localparam int KindW    = 2;
  localparam int PrioW    = 8;
  localparam int ExcCntW  = $clog2(ExcSlots + 1);
  localparam int RuleIdxW = (RuleSlots > 1) ? $clog2(RuleSlots) : 1;
  localparam int SlotW    = (ExcSlots > 1) ? $clog2(ExcSlots) : 1;
  localparam int RuleCntW = 7;

  localparam logic [1:0] CmdEval     = 2'd0;
  localparam logic [1:0] CmdWrRule   = 2'd1;
  localparam logic [1:0] CmdWrExcept = 2'd2;

  localparam logic [KindW-1:0] KindAllow     = 2'd0;
  localparam logic [KindW-1:0] KindDeny      = 2'd1;
  localparam logic [KindW-1:0] KindMandAllow = 2'd2;
  localparam logic [KindW-1:0] KindMandDeny  = 2'd3;

  typedef struct packed {
    logic [CallW-1:0]   call;
    logic [KindW-1:0]   kind;
    logic [PrioW-1:0]   prio;
    logic               all;
    logic [ExcCntW-1:0] exc_cnt;
  } rule_t;

  typedef logic [ExcSlots-1:0][CallW-1:0] exc_row_t;

  typedef struct packed {
    logic                rule_we;
    logic                exc_we;
    logic [RuleIdxW-1:0] idx;
    logic [SlotW-1:0]    slot;
    rule_t               rule;
    logic [CallW-1:0]    exc_val;
  } tbl_wr_t;

  typedef struct packed {
    logic             clear;
    logic             step;
    logic [CallW-1:0] call;
  } scan_ctrl_t;

  typedef struct packed {
    logic [KindW-1:0] decision;
    logic             deny;
    logic             matched;
  } result_t;

endpackage
`default_nettype wire

### rtl/srpc_tables.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srpc_tables: rule table and exception rows
// One rule entry and its whole exception row are read per cycle at the scan
// address, with registered read data. Writes go to one rule or one slot.
// ----------------------------------------------------------------------------
module srpc_tables
  import srpc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire tbl_wr_t             wr_i,
  input  wire logic [RuleIdxW-1:0] rd_addr_i,
  output rule_t                    rd_rule_o,
  output exc_row_t                 rd_exc_o
);

  rule_t    rule_mem_q [RuleSlots];
  exc_row_t exc_mem_q  [RuleSlots];
  rule_t    rd_rule_q;
  exc_row_t rd_exc_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.rule_we) begin
      rule_mem_q[wr_i.idx] <= wr_i.rule;
    end
    rd_rule_q <= rule_mem_q[rd_addr_i];
  end

  // Each slot of a row has its own write enable.
  always_ff @(posedge clk_i) begin
    if (wr_i.exc_we) begin
      exc_mem_q[wr_i.idx][wr_i.slot] <= wr_i.exc_val;
    end
    rd_exc_q <= exc_mem_q[rd_addr_i];
  end

  assign rd_rule_o = rd_rule_q;
  assign rd_exc_o  = rd_exc_q;

endmodule
`default_nettype wire

### rtl/srpc_scan_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srpc_scan_unit: shared rule compare and priority update
// Takes one rule and its exception row per step, decides whether the rule
// applies to the call and folds it into the running best decision.
// ----------------------------------------------------------------------------
module srpc_scan_unit
  import srpc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire scan_ctrl_t ctrl_i,
  input  wire rule_t      rule_i,
  input  wire exc_row_t   exc_i,
  output result_t         res_o
);

  logic [PrioW-1:0] best_q, best_d;
  logic [KindW-1:0] dec_q, dec_d;
  logic             matched_q, matched_d;
  logic [ExcSlots-1:0] exc_hit;
  logic             applies;

  always_comb begin
    for (int k = 0; k < ExcSlots; k++) begin
      exc_hit[k] = (ExcCntW'(k) < rule_i.exc_cnt) && (exc_i[k] == ctrl_i.call);
    end
    applies = rule_i.all ? !(|exc_hit) : (rule_i.call == ctrl_i.call);
  end

  always_comb begin
    best_d    = best_q;
    dec_d     = dec_q;
    matched_d = matched_q;
    if (ctrl_i.clear) begin
      best_d    = '0;
      dec_d     = KindAllow;
      matched_d = 1'b0;
    end else if (ctrl_i.step && applies) begin
      if (!matched_q || rule_i.prio > best_q) begin
        matched_d = 1'b1;
        best_d    = rule_i.prio;
        dec_d     = rule_i.kind;
      end else if (rule_i.prio == best_q &&
                   (rule_i.kind == KindMandAllow || rule_i.kind == KindMandDeny)) begin
        // At equal priority only a mandatory rule overrides.
        dec_d = rule_i.kind;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q    <= '0;
      dec_q     <= KindAllow;
      matched_q <= 1'b0;
    end else begin
      best_q    <= best_d;
      dec_q     <= dec_d;
      matched_q <= matched_d;
    end
  end

  assign res_o.decision = dec_q;
  assign res_o.deny     = (dec_q == KindDeny) || (dec_q == KindMandDeny);
  assign res_o.matched  = matched_q;

endmodule
`default_nettype wire

### rtl/syscall_rule_priority_classifier_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// syscall_rule_priority_classifier_unit: priority access rule classifier
// Stores up to 64 rules with exception rows and evaluates call numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, the command in tuser. Write
//   commands update the rule table or one exception slot and answer with
//   an all-zero result. An evaluate request scans rules 0 .. n-1, where n is
//   the rules_in_use register clamped to 64, one rule and its full exception
//   row per cycle through a single compare unit and the table read port.
//   An evaluation steps through the scan, drain and finish states; a write
//   or an evaluation with nothing to scan goes to finish. s_axis_tready is high only
//   while no request is in progress, so one request is handled at a time.
//   Results leave through an output register on m_axis; the next request
//   is accepted while a result waits, and a finished request holds until
//   the register is free when the receiver stalls.
//   The cfg channel writes rules_in_use and is always ready; write it only
//   while idle. Reset clears the control state and rules_in_use; table
//   contents are undefined until written.
// ----------------------------------------------------------------------------
module syscall_rule_priority_classifier_unit
  import srpc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: syscall_number[8:0], rule_index[14:9], rule_kind[16:15],
  // rule_priority[24:17], all_calls[25], exception_count[30:26],
  // exception_slot[34:31], zero fill above
  input  wire logic [39:0]         s_axis_tdata,
  // tuser: command[1:0]
  input  wire logic [1:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // tdata: decision[1:0], deny[2], rule_matched[3], zero fill above
  output logic [7:0]               m_axis_tdata,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [RuleCntW-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StFinish
  } state_e;

  state_e              state_q;
  logic [RuleIdxW-1:0] addr_q;
  logic [RuleIdxW-1:0] last_q;
  logic                pend_q;
  logic                m_valid_q;
  logic [7:0]          m_data_q;
  logic [CallW-1:0]    call_q;
  logic [RuleCntW-1:0] rules_in_use_q;

  logic [1:0]          cmd;
  logic [CallW-1:0]    in_call;
  logic [IdxInW-1:0]   in_idx;
  logic [KindW-1:0]    in_kind;
  logic [PrioW-1:0]    in_prio;
  logic                in_all;
  logic [4:0]          in_ecnt;
  logic [SlotInW-1:0]  in_slot;
  logic                accept;
  logic                idx_ok;
  logic                slot_ok;
  logic [RuleCntW-1:0] scan_cnt;
  logic                scan_go;

  tbl_wr_t    tbl_wr;
  rule_t      rd_rule;
  exc_row_t   rd_exc;
  scan_ctrl_t scan_ctrl;
  result_t    scan_res;

  assign cmd     = s_axis_tuser;
  assign in_call = s_axis_tdata[8:0];
  assign in_idx  = s_axis_tdata[14:9];
  assign in_kind = s_axis_tdata[16:15];
  assign in_prio = s_axis_tdata[24:17];
  assign in_all  = s_axis_tdata[25];
  assign in_ecnt = s_axis_tdata[30:26];
  assign in_slot = s_axis_tdata[34:31];

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign idx_ok   = (int'(in_idx) < RuleSlots);
  assign slot_ok  = (int'(in_slot) < ExcSlots);
  assign scan_cnt = (int'(rules_in_use_q) > RuleSlots) ? RuleCntW'(RuleSlots)
                                                       : rules_in_use_q;
  assign scan_go  = (cmd == CmdEval) && (scan_cnt != '0) && (int'(in_call) < CallLimit);

  always_comb begin
    tbl_wr.rule_we      = accept && (cmd == CmdWrRule) && idx_ok;
    tbl_wr.exc_we       = accept && (cmd == CmdWrExcept) && idx_ok && slot_ok;
    tbl_wr.idx          = in_idx[RuleIdxW-1:0];
    tbl_wr.slot         = in_slot[SlotW-1:0];
    tbl_wr.rule.call    = in_call;
    tbl_wr.rule.kind    = in_kind;
    tbl_wr.rule.prio    = in_prio;
    tbl_wr.rule.all     = in_all;
    tbl_wr.rule.exc_cnt = (int'(in_ecnt) > ExcSlots) ? ExcCntW'(ExcSlots)
                                                     : ExcCntW'(in_ecnt);
    tbl_wr.exc_val      = in_call;
  end

  srpc_tables u_tables (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (addr_q),
    .rd_rule_o (rd_rule),
    .rd_exc_o  (rd_exc)
  );

  // Every request clears the running result, so writes answer with zeros.
  assign scan_ctrl.clear = accept;
  assign scan_ctrl.step  = pend_q;
  assign scan_ctrl.call  = call_q;

  srpc_scan_unit u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .rule_i (rd_rule),
    .exc_i  (rd_exc),
    .res_o  (scan_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_in_use_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rules_in_use_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      addr_q    <= '0;
      last_q    <= '0;
      pend_q    <= 1'b0;
      call_q    <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_axis_tready && (state_q != StFinish)) begin
        m_valid_q <= 1'b0;
      end
      // The read issued during a scan cycle returns next cycle for the scan unit.
      pend_q <= (state_q == StScan);
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            call_q <= in_call;
            addr_q <= '0;
            last_q <= RuleIdxW'(scan_cnt - 1'b1);
            state_q <= scan_go ? StScan : StFinish;
          end
        end
        StScan: begin
          if (addr_q == last_q) begin
            state_q <= StDrain;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        StDrain: begin
          state_q <= StFinish;
        end
        StFinish: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {4'b0, scan_res.matched, scan_res.deny, scan_res.decision};
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_scan_addr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (addr_q <= last_q))
    else $error("scan address passed the last rule");

  a_pend_from_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(state_q) == StScan))
    else $error("scan step without a read issued");

  a_deny_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_data_q[2] == m_data_q[0]))
    else $error("deny flag disagrees with decision");

  a_nomatch_allow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_data_q[3]) |-> (m_data_q[1:0] == KindAllow))
    else $error("decision set without a matching rule");

endmodule
`default_nettype wire
